// ===== hw/rtl/ble_adv_packet_encoder_top_macros.svh =====
// Assertion helpers shared by the RTL. All checks sample on clk and are
// quiet while arst_n is low.
`ifndef BLE_ADV_PACKET_ENCODER_TOP_MACROS_SVH
`define BLE_ADV_PACKET_ENCODER_TOP_MACROS_SVH

// Same-cycle implication
`define BLE_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication
`define BLE_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== hw/rtl/bleenc_pkg.sv =====
`default_nettype none

package bleenc_pkg;

	localparam int CFG_DATA_W  = 24;
	localparam int CFG_INDEX_W = 2;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	typedef logic [CFG_DATA_W-1:0]  cfg_data_t;
	typedef logic [23:0]            crc_t;
	typedef logic [7:0]             byte_t;
	typedef logic [5:0]             chan_t;
	typedef logic [1:0]             tail_cnt_t;

	// Configuration register indexes
	localparam cfg_index_t CFG_CHANNEL  = 2'd0;
	localparam cfg_index_t CFG_CRC_SEED = 2'd1;

	localparam chan_t RESET_CHANNEL  = 6'd37;
	localparam crc_t  RESET_CRC_SEED = 24'h555555;

	localparam crc_t  CRC_POLY    = 24'h00065B;
	localparam byte_t WHITEN_TAPS = 8'h11;
	localparam byte_t WHITEN_OR   = 8'h02;

	// CRC tail countdown: bytes still to send
	localparam tail_cnt_t TAIL_IDLE = 2'd0;
	localparam tail_cnt_t TAIL_LAST = 2'd1;
	localparam tail_cnt_t TAIL_MID  = 2'd2;
	localparam tail_cnt_t TAIL_FULL = 2'd3;

	typedef struct packed {
		byte_t lfsr;
		byte_t data;
	} whiten_res_t;

	function automatic byte_t flip8(input byte_t v);
		byte_t r;
		for (int k = 0; k < 8; k++) begin
			r[7-k] = v[k];
		end
		return r;
	endfunction

	function automatic byte_t whiten_seed(input chan_t ch);
		return flip8({2'b00, ch}) | WHITEN_OR;
	endfunction

	// Eight CRC steps, data LSB first
	function automatic crc_t crc_feed8(input crc_t crc, input byte_t b);
		crc_t c;
		logic top;
		c = crc;
		for (int k = 0; k < 8; k++) begin
			top = c[23];
			c   = {c[22:0], 1'b0};
			if (top != b[k]) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	// Eight LFSR steps, one per data bit starting at the LSB
	function automatic whiten_res_t whiten8(input byte_t lfsr, input byte_t b);
		whiten_res_t r;
		r.lfsr = lfsr;
		r.data = b;
		for (int k = 0; k < 8; k++) begin
			if (r.lfsr[7]) begin
				r.lfsr    = r.lfsr ^ WHITEN_TAPS;
				r.data[k] = ~r.data[k];
			end
			r.lfsr = {r.lfsr[6:0], 1'b0};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ble_adv_packet_encoder_top.sv =====
// BLE advertising PDU encoder: takes one header or payload byte per beat,
// runs it through the CRC-24 register and the data-whitening LFSR, and gives
// one whitened, bit-reversed byte per beat. A byte marked last is followed by
// the three CRC bytes (crc_part high, packet_end on the third), after which
// both registers reload from the channel and CRC seed registers for the next
// packet. Throughput is one byte per clock while out_stall is low and no CRC
// tail is in progress; in_stall stays high while the CRC bytes go out through
// the output register. Config writes take effect at the next packet start.
// No clearing pass after reset.
`default_nettype none
`include "ble_adv_packet_encoder_top_macros.svh"

module ble_adv_packet_encoder_top (
	input  wire                     clk,
	input  wire                     arst_n,
	// configuration
	input  wire                     cfg_we,
	input  wire bleenc_pkg::cfg_index_t cfg_index,
	input  wire bleenc_pkg::cfg_data_t  cfg_data,
	// input beats
	input  wire                     in_valid,
	output logic                    in_stall,
	input  wire [7:0]               pdu_byte,
	input  wire                     pdu_last,
	// output beats
	output logic                    out_valid,
	input  wire                     out_stall,
	output logic [7:0]              coded_byte,
	output logic                    crc_part,
	output logic                    packet_end
);
	import bleenc_pkg::*;

	chan_t       chan_q;
	crc_t        seed_q;
	crc_t        crc_q;
	byte_t       wht_q;
	logic        start_q;
	tail_cnt_t   tail_q;
	logic        out_valid_q;
	byte_t       coded_q;
	logic        crc_part_q;
	logic        end_q;

	logic        out_load;
	logic        in_acc;
	logic        tail_step;
	crc_t        crc_base;
	byte_t       wht_base;
	crc_t        crc_next;
	whiten_res_t wr_dat;
	byte_t       tail_sel;
	whiten_res_t wr_tail;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= RESET_CHANNEL;
			seed_q <= RESET_CRC_SEED;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHANNEL:  chan_q <= cfg_data[5:0];
				CFG_CRC_SEED: seed_q <= cfg_data[23:0];
				default:      ;
			endcase
		end
	end

	// Handshake
	assign out_load  = !out_valid_q || !out_stall;
	assign in_stall  = (tail_q != TAIL_IDLE) || !out_load;
	assign in_acc    = in_valid && !in_stall;
	assign tail_step = (tail_q != TAIL_IDLE) && out_load;

	// Data byte path: reload at packet start
	assign crc_base = start_q ? seed_q : crc_q;
	assign wht_base = start_q ? whiten_seed(chan_q) : wht_q;
	assign crc_next = crc_feed8(crc_base, pdu_byte);
	assign wr_dat   = whiten8(wht_base, pdu_byte);

	// CRC tail path, high byte first
	always_comb begin
		case (tail_q)
			TAIL_FULL: tail_sel = crc_q[23:16];
			TAIL_MID:  tail_sel = crc_q[15:8];
			default:   tail_sel = crc_q[7:0];
		endcase
	end
	assign wr_tail = whiten8(wht_q, flip8(tail_sel));

	// Running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
			tail_q  <= TAIL_IDLE;
		end else if (in_acc) begin
			start_q <= pdu_last;
			tail_q  <= pdu_last ? TAIL_FULL : TAIL_IDLE;
		end else if (tail_step) begin
			tail_q  <= tail_q - TAIL_LAST;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			crc_q <= crc_next;
			wht_q <= wr_dat.lfsr;
		end else if (tail_step) begin
			wht_q <= wr_tail.lfsr;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= in_acc || tail_step;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			coded_q    <= flip8(wr_dat.data);
			crc_part_q <= 1'b0;
			end_q      <= 1'b0;
		end else if (tail_step) begin
			coded_q    <= flip8(wr_tail.data);
			crc_part_q <= 1'b1;
			end_q      <= (tail_q == TAIL_LAST);
		end
	end

	assign out_valid  = out_valid_q;
	assign coded_byte = coded_q;
	assign crc_part   = crc_part_q;
	assign packet_end = end_q;

	// Checks
	`BLE_ASSERT_NEXT(a_last_starts_tail, in_acc && pdu_last, tail_q == TAIL_FULL,
		"last byte did not start the CRC tail")
	`BLE_ASSERT_NOW(a_tail_holds_out, tail_q != TAIL_IDLE, out_valid_q,
		"output register empty during CRC tail")
	`BLE_ASSERT_NOW(a_end_is_crc, out_valid_q && end_q, crc_part_q,
		"packet end on a non-CRC byte")
	`BLE_ASSERT_NOW(a_end_rearms, out_valid_q && end_q, start_q && tail_q == TAIL_IDLE,
		"packet end shown without rearmed packet start")

endmodule

`default_nettype wire
